>>> rtl/blst_pkg.sv
// package with shared types and constants of the bounded ordered list
`timescale 1ns / 1ps
package blst_pkg;

   localparam int VALUE_W  = 32;
   localparam int OP_W     = 3;
   localparam int INDEX_W  = 5;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FIRST = 3'd3,
      OP_DEL_LAST  = 3'd4,
      OP_DUMP      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ROW_HOLD,
      ROW_INS_FRONT,
      ROW_INS_BACK,
      ROW_INS_AT,
      ROW_DEL_FIRST,
      ROW_DEL_LAST,
      ROW_ROTATE
   } row_op_type;

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   typedef struct packed {
      row_op_type row_op;
      logic       rsp_en;
      status_type status;
      logic       rsp_last;
      logic       rsp_dump;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic dump_last;
   } dp_stat_type;

endpackage

>>> rtl/bounded_ordered_list.sv
// top level of the bounded ordered list
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values.
// Input: a transaction is taken at a rising edge with start high and busy low;
// req_op selects insert front / back / at req_index, delete first / last, or dump.
// Output: each result sits on rsp_* for one cycle with rsp_strobe high.
// Insert and delete ops give a single result (status, new count,
// rsp_last high) that appears the cycle after acceptance, and busy stays low, so a
// new transaction may follow in every cycle.
// A dump of N entries holds busy high while the controller is in S_DUMP; the entry
// row rotates by one position each cycle, so result k leaves the front register and
// the row is back in order after the last one. Results appear one per cycle, after
// the state register and then the response register, the last one marked by rsp_last.
// A dump of an empty list returns one result with status empty.
// Reset (synchronous) empties the list and drops any dump in progress.
// The receiver cannot stall: every result is taken in its strobe cycle.
module bounded_ordered_list #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [blst_pkg::OP_W-1:0]           req_op,
   input  logic signed [blst_pkg::VALUE_W-1:0] req_value,
   input  logic [blst_pkg::INDEX_W-1:0]        req_index,
   output logic                               rsp_strobe,
   output logic signed [blst_pkg::VALUE_W-1:0] rsp_value_res,
   output logic [blst_pkg::STATUS_W-1:0]       rsp_status,
   output logic [blst_pkg::COUNT_W-1:0]        rsp_count,
   output logic                               rsp_last
);
   import blst_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   blst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   blst_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_value     (req_value),
      .req_index     (req_index),
      .stat          (stat),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_last      (rsp_last)
   );

   a_op_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op != OP_DUMP) |=> rsp_strobe && rsp_last)
      else $error("accepted transaction gave no single result");

endmodule

>>> rtl/blst_ctrl.sv
// controller state machine of the bounded ordered list
`timescale 1ns / 1ps
module blst_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [blst_pkg::OP_W-1:0] req_op,
   input  blst_pkg::dp_stat_type    stat,
   output logic                     busy,
   output blst_pkg::dp_cmd_type     cmd
);
   import blst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      busy         = 1'b0;
      cmd.row_op   = ROW_HOLD;
      cmd.rsp_en   = 1'b0;
      cmd.status   = ST_OK;
      cmd.rsp_last = 1'b1;
      cmd.rsp_dump = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.rsp_en = 1'b1;
               case (req_op)
                  OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else if (req_op == OP_INS_FRONT) begin
                        cmd.row_op = ROW_INS_FRONT;
                     end else if (req_op == OP_INS_BACK) begin
                        cmd.row_op = ROW_INS_BACK;
                     end else begin
                        cmd.row_op = ROW_INS_AT;
                     end
                  end
                  OP_DEL_FIRST: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.row_op = ROW_DEL_FIRST;
                     end
                  end
                  OP_DEL_LAST: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.row_op = ROW_DEL_LAST;
                     end
                  end
                  OP_DUMP: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.rsp_en = 1'b0;
                        state_in   = S_DUMP;
                     end
                  end
                  default: begin
                     cmd.status = ST_OK;
                  end
               endcase
            end
         end
         S_DUMP: begin
            busy         = 1'b1;
            cmd.row_op   = ROW_ROTATE;
            cmd.rsp_en   = 1'b1;
            cmd.rsp_dump = 1'b1;
            cmd.rsp_last = stat.dump_last;
            if (stat.dump_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_dump_not_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> !stat.empty)
      else $error("dump running on an empty list");

endmodule

>>> rtl/blst_dpath.sv
// datapath of the bounded ordered list: shifting entry row, count and response register
`timescale 1ns / 1ps
module blst_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  blst_pkg::dp_cmd_type               cmd,
   input  logic signed [blst_pkg::VALUE_W-1:0] req_value,
   input  logic [blst_pkg::INDEX_W-1:0]        req_index,
   output blst_pkg::dp_stat_type              stat,
   output logic                               rsp_strobe,
   output logic signed [blst_pkg::VALUE_W-1:0] rsp_value_res,
   output logic [blst_pkg::STATUS_W-1:0]       rsp_status,
   output logic [blst_pkg::COUNT_W-1:0]        rsp_count,
   output logic                               rsp_last
);
   import blst_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [VALUE_W-1:0] row_ff [CAPACITY];
   logic [VALUE_W-1:0] row_in [CAPACITY];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      rot_cnt_ff;
   logic [CW-1:0]      rot_cnt_in;
   logic [CW-1:0]      pos;
   logic [CW-1:0]      last_pos;
   logic [PW-1:0]      idx_ext;
   logic [PW-1:0]      cnt_ext;
   logic [PW-1:0]      count_ext;
   logic               strobe_ff;
   logic [VALUE_W-1:0] value_ff;
   status_type         status_ff;
   logic [COUNT_W-1:0] rcount_ff;
   logic               last_ff;

   assign idx_ext   = PW'(req_index);
   assign cnt_ext   = PW'(count_ff);
   assign last_pos  = count_ff - CW'(1);
   assign count_ext = PW'(count_in);

   always_comb begin
      case (cmd.row_op)
         ROW_INS_FRONT: pos = '0;
         ROW_INS_BACK:  pos = count_ff;
         ROW_INS_AT:    pos = (idx_ext > cnt_ext) ? count_ff : CW'(idx_ext);
         default:       pos = count_ff;
      endcase
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
      always_comb begin
         row_in[g] = row_ff[g];
         case (cmd.row_op)
            ROW_INS_FRONT, ROW_INS_BACK, ROW_INS_AT: begin
               if (CW'(g) == pos) begin
                  row_in[g] = req_value;
               end else if (CW'(g) > pos) begin
                  if (g > 0) begin
                     row_in[g] = row_ff[(g > 0) ? g - 1 : 0];
                  end
               end
            end
            ROW_DEL_FIRST: begin
               if (g < CAPACITY - 1) begin
                  row_in[g] = row_ff[(g < CAPACITY - 1) ? g + 1 : g];
               end
            end
            ROW_ROTATE: begin
               if (CW'(g) == last_pos) begin
                  row_in[g] = row_ff[0];
               end else if (g < CAPACITY - 1) begin
                  row_in[g] = row_ff[(g < CAPACITY - 1) ? g + 1 : g];
               end
            end
            default: begin
               row_in[g] = row_ff[g];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         row_ff[g] <= row_in[g];
      end
   end

   always_comb begin
      case (cmd.row_op)
         ROW_INS_FRONT, ROW_INS_BACK, ROW_INS_AT: count_in = count_ff + CW'(1);
         ROW_DEL_FIRST, ROW_DEL_LAST:             count_in = count_ff - CW'(1);
         default:                                 count_in = count_ff;
      endcase
      rot_cnt_in = (cmd.row_op == ROW_ROTATE) ? rot_cnt_ff + CW'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rot_cnt_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         rot_cnt_ff <= rot_cnt_in;
         strobe_ff  <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= cmd.rsp_dump ? row_ff[0] : '0;
      status_ff <= cmd.status;
      rcount_ff <= count_ext[COUNT_W-1:0];
      last_ff   <= cmd.rsp_last;
   end

   assign stat.full      = (count_ff == CW'(CAPACITY));
   assign stat.empty     = (count_ff == '0);
   assign stat.dump_last = (rot_cnt_ff == last_pos);

   assign rsp_strobe    = strobe_ff;
   assign rsp_value_res = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_count     = rcount_ff;
   assign rsp_last      = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.row_op == ROW_INS_FRONT || cmd.row_op == ROW_INS_BACK ||
       cmd.row_op == ROW_INS_AT) |=> count_ff == CW'($past(count_ff) + CW'(1)))
      else $error("insert did not grow the list");

   a_del_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.row_op == ROW_DEL_FIRST || cmd.row_op == ROW_DEL_LAST)
      |=> count_ff == CW'($past(count_ff) - CW'(1)))
      else $error("delete did not shrink the list");

endmodule
